// ===== rtl/fpa_pkg.sv =====
// Shared types, constants and saturation helper for the fixed-point ALU.
package fpa_pkg;

    localparam int FRAC_BITS = 8;
    localparam int NUM_W     = 33 + FRAC_BITS;
    localparam int DEN_W     = 33;
    localparam int MAG_W     = 65;

    typedef enum logic [3:0] {
        F_ADD    = 4'd0,
        F_SUB    = 4'd1,
        F_MUL    = 4'd2,
        F_DIV    = 4'd3,
        F_LT     = 4'd4,
        F_GT     = 4'd5,
        F_LE     = 4'd6,
        F_GE     = 4'd7,
        F_EQ     = 4'd8,
        F_NE     = 4'd9,
        F_MIN    = 4'd10,
        F_MAX    = 4'd11,
        F_INC    = 4'd12,
        F_DEC    = 4'd13,
        F_TO_INT = 4'd14
    } t_func;

    typedef enum logic [1:0] {
        E_NONE = 2'd0,
        E_OVF  = 2'd1,
        E_DIV0 = 2'd2
    } t_err;

    typedef struct packed {
        t_func              func;
        logic        [31:0] res;
        logic               cmp;
        t_err               err;
        logic signed [63:0] prod;
        logic               qneg;
    } t_side;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
        logic [DEN_W-1:0] rem;
        logic [NUM_W-1:0] quo;
    } t_div;

    // Applies a sign to a magnitude and saturates; bit 32 of the result flags overflow.
    function automatic logic [32:0] sat_mag(input logic neg, input logic [MAG_W-1:0] mag);
        logic [32:0] r;
        if (neg) begin
            if (mag > MAG_W'(64'h8000_0000)) r = {1'b1, 32'h8000_0000};
            else r = {1'b0, 32'(-mag)};
        end else begin
            if (mag > MAG_W'(64'h7FFF_FFFF)) r = {1'b1, 32'h7FFF_FFFF};
            else r = {1'b0, mag[31:0]};
        end
        return r;
    endfunction

endpackage

// ===== rtl/fpa_pre.sv =====
// First stage: decode, simple operations, multiplier and divider setup.
module fpa_pre
    import fpa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic [3:0]  i_func,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic        o_valid,
    output t_side       o_side,
    output t_div        o_div
);

    logic        r_valid;
    t_side       r_side, n_side;
    t_div        r_div, n_div;
    logic [32:0] w_sum;
    logic [31:0] w_mag_a, w_mag_b;
    logic        w_lt, w_eq;

    always_comb begin
        w_mag_a = i_a[31] ? 32'(-i_a) : i_a;
        w_mag_b = i_b[31] ? 32'(-i_b) : i_b;
        w_lt    = $signed(i_a) < $signed(i_b);
        w_eq    = i_a == i_b;
        n_side       = '0;
        n_side.func  = t_func'(i_func);
        n_side.err   = E_NONE;
        n_side.prod  = $signed(i_a) * $signed(i_b);
        n_side.qneg  = i_a[31] ^ i_b[31];
        n_div.num    = (NUM_W'(w_mag_a) << (FRAC_BITS + 1)) + NUM_W'(w_mag_b);
        n_div.den    = {w_mag_b, 1'b0};
        n_div.rem    = '0;
        n_div.quo    = '0;
        case (i_func)
            F_ADD:   w_sum = {i_a[31], i_a} + {i_b[31], i_b};
            F_SUB:   w_sum = {i_a[31], i_a} - {i_b[31], i_b};
            F_INC:   w_sum = {i_a[31], i_a} + 33'd1;
            F_DEC:   w_sum = {i_a[31], i_a} - 33'd1;
            default: w_sum = '0;
        endcase
        case (i_func)
            F_ADD, F_SUB, F_INC, F_DEC: begin
                if (w_sum[32] != w_sum[31]) begin
                    n_side.res = w_sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                    n_side.err = E_OVF;
                end else begin
                    n_side.res = w_sum[31:0];
                end
            end
            F_DIV:    if (i_b == '0) n_side.err = E_DIV0;
            F_LT:     n_side.cmp = w_lt;
            F_GT:     n_side.cmp = !w_lt && !w_eq;
            F_LE:     n_side.cmp = w_lt || w_eq;
            F_GE:     n_side.cmp = !w_lt;
            F_EQ:     n_side.cmp = w_eq;
            F_NE:     n_side.cmp = !w_eq;
            F_MIN:    n_side.res = (w_lt || w_eq) ? i_a : i_b;
            F_MAX:    n_side.res = (!w_lt && !w_eq) ? i_a : i_b;
            F_TO_INT: n_side.res = 32'($signed(i_a) >>> FRAC_BITS);
            default:  n_side.res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= n_side;
            r_div  <= n_div;
        end
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_div   = r_div;

endmodule

// ===== rtl/fpa_div_step.sv =====
// One restoring division step, one quotient bit per stage.
module fpa_div_step
    import fpa_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_side i_side,
    input  t_div  i_div,
    output logic  o_valid,
    output t_side o_side,
    output t_div  o_div
);

    logic             r_valid;
    t_side            r_side;
    t_div             r_div, n_div;
    logic [DEN_W:0]   w_rem2;
    logic             w_ge;

    always_comb begin
        w_rem2    = {i_div.rem, i_div.num[NUM_W-1]};
        w_ge      = w_rem2 >= {1'b0, i_div.den};
        n_div.den = i_div.den;
        n_div.num = i_div.num << 1;
        n_div.quo = {i_div.quo[NUM_W-2:0], w_ge};
        n_div.rem = w_ge ? DEN_W'(w_rem2 - {1'b0, i_div.den}) : w_rem2[DEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= i_side;
            r_div  <= n_div;
        end
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_div   = r_div;

endmodule

// ===== rtl/fpa_post.sv =====
// Last stage: product rounding, quotient saturation and result select.
module fpa_post
    import fpa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  t_side       i_side,
    input  t_div        i_div,
    output logic        o_valid,
    output logic [31:0] o_result,
    output logic        o_cmp,
    output t_err        o_err
);

    localparam logic [MAG_W-1:0] RND =
        (FRAC_BITS == 0) ? '0 : MAG_W'(1) << ((FRAC_BITS == 0) ? 0 : FRAC_BITS - 1);

    logic              r_valid;
    logic [31:0]       r_result, n_result;
    logic              r_cmp;
    t_err              r_err, n_err;
    logic [63:0]       w_pmag;
    logic [MAG_W-1:0]  w_pq;
    logic [32:0]       w_sat;

    always_comb begin
        w_pmag   = i_side.prod[63] ? 64'(-i_side.prod) : i_side.prod;
        w_pq     = (MAG_W'(w_pmag) + RND) >> FRAC_BITS;
        n_result = i_side.res;
        n_err    = i_side.err;
        case (i_side.func)
            F_MUL:   w_sat = sat_mag(i_side.prod[63], w_pq);
            F_DIV:   w_sat = sat_mag(i_side.qneg, MAG_W'(i_div.quo));
            default: w_sat = '0;
        endcase
        if (i_side.func == F_MUL || (i_side.func == F_DIV && i_side.err != E_DIV0)) begin
            n_result = w_sat[31:0];
            n_err    = w_sat[32] ? E_OVF : E_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_result <= n_result;
            r_cmp    <= i_side.cmp;
            r_err    <= n_err;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;
    assign o_cmp    = r_cmp;
    assign o_err    = r_err;

endmodule

// ===== rtl/fixed_point_alu.sv =====
// Top level of the pipelined signed fixed-point ALU.
// Every operation takes the same path: one setup stage with the multiplier, one stage per
// quotient bit of the restoring divider (FRAC_BITS + 33 stages), and one result stage. A new
// beat is taken every cycle; the whole pipeline holds while the output beat waits to be taken.
module fixed_point_alu
    import fpa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [71:0] i_s_tdata,  // func[3:0], operand_a[35:4], operand_b[67:36], zeros
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata   // result_value[31:0], compare_true[32], error_code[34:33]
);

    logic        w_en;
    logic        w_vld  [0:NUM_W];
    t_side       w_side [0:NUM_W];
    t_div        w_div  [0:NUM_W];
    logic [31:0] w_result;
    logic        w_cmp;
    t_err        w_err;

    assign w_en       = !o_m_tvalid || i_m_tready;
    assign o_s_tready = w_en;

    fpa_pre u_pre (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_s_tvalid),
        .i_func  (i_s_tdata[3:0]),
        .i_a     (i_s_tdata[35:4]),
        .i_b     (i_s_tdata[67:36]),
        .o_valid (w_vld[0]),
        .o_side  (w_side[0]),
        .o_div   (w_div[0])
    );

    for (genvar g = 0; g < NUM_W; g++) begin : g_div
        fpa_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_vld[g]),
            .i_side  (w_side[g]),
            .i_div   (w_div[g]),
            .o_valid (w_vld[g+1]),
            .o_side  (w_side[g+1]),
            .o_div   (w_div[g+1])
        );
    end

    fpa_post u_post (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (w_vld[NUM_W]),
        .i_side   (w_side[NUM_W]),
        .i_div    (w_div[NUM_W]),
        .o_valid  (o_m_tvalid),
        .o_result (w_result),
        .o_cmp    (w_cmp),
        .o_err    (w_err)
    );

    assign o_m_tdata = {5'd0, w_err, w_cmp, w_result};

    a_cmp_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && w_cmp) |-> (w_result == '0 && w_err == E_NONE))
        else $error("compare beat carries a value or an error");

    a_div0_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && w_err == E_DIV0) |-> (w_result == '0))
        else $error("divide by zero beat has a nonzero value");

    a_ovf_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && w_err == E_OVF) |->
        (w_result == 32'h7FFF_FFFF || w_result == 32'h8000_0000))
        else $error("overflow beat is not saturated");

endmodule
